// ===== rtl/isq_pkg.sv =====
// Shared types and constants of the indexed sequence store.
// Holds the transaction structs, the opcode and status codes and the
// controller-to-datapath command and status structs. Depends on nothing.
package isq_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int WORD_W   = 32;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic [POS_W-1:0]           position;
    logic signed [WORD_W-1:0]   data_word;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]   read_word;
    status_t                    status;
    logic [LEN_W-1:0]           length;
  } out_item_t;

  // Read address sources of the element memory.
  typedef enum logic [1:0] {
    RA_POS    = 2'd0,
    RA_IDX_DN = 2'd1,
    RA_IDX_UP = 2'd2
  } rd_sel_t;

  // Write address and data sources of the element memory.
  typedef enum logic {
    WA_POS_WORD  = 1'b0,
    WA_IDX_SHIFT = 1'b1
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    check;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    idx_load_cnt;
    logic    idx_load_pos;
    logic    idx_dec;
    logic    idx_inc;
    logic    capture;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    err;
    logic    ins_at_pos;
    logic    del_last;
  } dp_stat_t;

  // Length as reported: the count masked to the field width.
  function automatic logic [LEN_W-1:0] len_of(input logic [CNT_W-1:0] cnt);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(cnt);
    return wide[LEN_W-1:0];
  endfunction

endpackage

// ===== rtl/isq_ctrl.sv =====
// Controller of the indexed sequence store: a one-hot state machine that
// sequences checks, reads and element shifts. Depends on isq_pkg.
module isq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  isq_pkg::dp_stat_t stat,
  output isq_pkg::dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CHECK   = 8'b0000_0010,
    S_RD_WAIT = 8'b0000_0100,
    S_INS_STP = 8'b0000_1000,
    S_INS_WR  = 8'b0001_0000,
    S_DEL_STP = 8'b0010_0000,
    S_DEL_WR  = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.err) begin
          state_nxt = S_DONE;
        end else begin
          case (stat.op)
            isq_pkg::OP_GET: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = isq_pkg::RA_POS;
              state_nxt  = S_RD_WAIT;
            end
            isq_pkg::OP_SET: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = isq_pkg::WA_POS_WORD;
              state_nxt  = S_DONE;
            end
            isq_pkg::OP_INSERT: begin
              cmd.idx_load_cnt = 1'b1;
              state_nxt        = S_INS_STP;
            end
            default: begin
              cmd.rd_en        = 1'b1;
              cmd.rd_sel       = isq_pkg::RA_POS;
              cmd.idx_load_pos = 1'b1;
              state_nxt        = S_RD_WAIT;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = (stat.op == isq_pkg::OP_DELETE) ? S_DEL_STP : S_DONE;
      end
      S_INS_STP: begin
        if (stat.ins_at_pos) begin
          // Every later word has moved up; the new word goes in the gap.
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = isq_pkg::WA_POS_WORD;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = isq_pkg::RA_IDX_DN;
          state_nxt  = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = isq_pkg::WA_IDX_SHIFT;
        cmd.idx_dec = 1'b1;
        state_nxt   = S_INS_STP;
      end
      S_DEL_STP: begin
        if (stat.del_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = isq_pkg::RA_IDX_UP;
          state_nxt  = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = isq_pkg::WA_IDX_SHIFT;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_DEL_STP;
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/isq_datapath.sv =====
// Datapath of the indexed sequence store: element memory, length counter,
// shift index, error checks and the result register. Depends on isq_pkg.
module isq_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  isq_pkg::in_item_t  in_item,
  input  isq_pkg::dp_cmd_t   cmd,
  output isq_pkg::dp_stat_t  stat,
  output logic               out_valid,
  output isq_pkg::out_item_t out_item
);

  logic [isq_pkg::WORD_W-1:0] mem [isq_pkg::CAPACITY];

  isq_pkg::in_item_t          item_r;
  logic [isq_pkg::CNT_W-1:0]  count_r;
  logic [isq_pkg::CNT_W-1:0]  idx_r;
  logic [isq_pkg::WORD_W-1:0] rd_data_r;
  logic [isq_pkg::WORD_W-1:0] res_word_r;
  isq_pkg::status_t           status_r;
  isq_pkg::out_item_t         out_item_r;
  logic                       out_valid_r;

  logic [isq_pkg::CMP_W-1:0]  pos_x;
  logic [isq_pkg::CMP_W-1:0]  cnt_x;
  logic [isq_pkg::CMP_W-1:0]  idx_x;
  logic [isq_pkg::CNT_W-1:0]  idx_dn;
  logic [isq_pkg::CNT_W-1:0]  idx_up;
  logic [isq_pkg::AW-1:0]     rd_addr;
  logic [isq_pkg::AW-1:0]     wr_addr;
  logic [isq_pkg::WORD_W-1:0] wr_data;
  isq_pkg::status_t           chk_status;

  assign pos_x  = isq_pkg::CMP_W'(item_r.position);
  assign cnt_x  = isq_pkg::CMP_W'(count_r);
  assign idx_x  = isq_pkg::CMP_W'(idx_r);
  assign idx_dn = idx_r - 1'b1;
  assign idx_up = idx_r + 1'b1;

  // Full and empty take precedence over the index check.
  always_comb begin
    chk_status = isq_pkg::ST_OK;
    case (item_r.opcode)
      isq_pkg::OP_GET, isq_pkg::OP_SET: begin
        if (pos_x >= cnt_x) chk_status = isq_pkg::ST_RANGE;
      end
      isq_pkg::OP_INSERT: begin
        if (count_r >= isq_pkg::CNT_W'(isq_pkg::CAPACITY)) begin
          chk_status = isq_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          chk_status = isq_pkg::ST_RANGE;
        end
      end
      default: begin
        if (count_r == '0) begin
          chk_status = isq_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          chk_status = isq_pkg::ST_RANGE;
        end
      end
    endcase
  end

  assign stat.op         = item_r.opcode;
  assign stat.err        = (chk_status != isq_pkg::ST_OK);
  assign stat.ins_at_pos = (idx_x == pos_x);
  assign stat.del_last   = (idx_up >= count_r);

  always_comb begin
    case (cmd.rd_sel)
      isq_pkg::RA_POS:    rd_addr = pos_x[isq_pkg::AW-1:0];
      isq_pkg::RA_IDX_DN: rd_addr = idx_dn[isq_pkg::AW-1:0];
      isq_pkg::RA_IDX_UP: rd_addr = idx_up[isq_pkg::AW-1:0];
      default:            rd_addr = pos_x[isq_pkg::AW-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      isq_pkg::WA_IDX_SHIFT: begin
        wr_addr = idx_r[isq_pkg::AW-1:0];
        wr_data = rd_data_r;
      end
      default: begin
        wr_addr = pos_x[isq_pkg::AW-1:0];
        wr_data = item_r.data_word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.check) begin
      status_r   <= chk_status;
      res_word_r <= (chk_status != isq_pkg::ST_OK) ? '1 : '0;
    end else if (cmd.capture) begin
      res_word_r <= rd_data_r;
    end
    if (cmd.idx_load_cnt) begin
      idx_r <= count_r;
    end else if (cmd.idx_load_pos) begin
      idx_r <= pos_x[isq_pkg::CNT_W-1:0];
    end else if (cmd.idx_dec) begin
      idx_r <= idx_dn;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_up;
    end
    if (cmd.emit) begin
      out_item_r.read_word <= res_word_r;
      out_item_r.status    <= status_r;
      out_item_r.length    <= isq_pkg::len_of(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/indexed_sequence_store_top.sv =====
// After acceptance the request is checked; set and any error then yield the result,
// get waits for its read, insert moves length - index words up, delete reads its
// word and moves length - index - 1 words down. One transaction at a time; each
// moved word takes a read and a write of the element memory (registered read data).
// busy falls in the cycle the strobe is high; results cannot be stalled.
// Synchronous active-low reset empties the store; memory contents are not cleared.
module indexed_sequence_store_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  isq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output isq_pkg::out_item_t out_item
);

  isq_pkg::dp_cmd_t  cmd;
  isq_pkg::dp_stat_t stat;

  isq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  isq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/isq_checker.sv =====
// Port-level checks of the indexed sequence store and the bind that attaches
// them to indexed_sequence_store_top. Depends on isq_pkg.
module isq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input isq_pkg::out_item_t out_item
);

  // An accepted transaction keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted transaction");

  // Each transaction yields a single strobe, never two in a row.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The result is shown as the block returns to idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  // A failed transaction always reports the all-ones word.
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != isq_pkg::ST_OK)) |-> (out_item.read_word == '1))
    else $error("error result without the all-ones word");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

endmodule

bind indexed_sequence_store_top isq_checker u_isq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
